/* rtl/core/sols_pkg.sv */
package sols_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNTR_W      = $clog2(TABLE_DEPTH + 1);

  localparam int VAL_W      = 32;
  localparam int CNT_W      = 32;
  localparam int MODE_W     = 2;
  localparam int LEN_W      = 11;
  localparam int LOAD_IDX_W = 10;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_REORDER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH  = 1'd1;

  localparam logic [MODE_W-1:0] MODE_FIRST     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT     = 2'd2;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_READ_P,
    ST_WAIT_P,
    ST_WRITE_H,
    ST_WRITE_P,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic start;
    logic clear_wr;
    logic load_wr;
    logic scan;
    logic read_p;
    logic latch_p;
    logic write_h;
    logic write_p;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
    logic miss;
    logic do_reorder;
    logic swap_ok;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/sols_ram.sv */
module sols_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/sols_ctrl.sv */
module sols_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_action,
  input  sols_pkg::sts_t sts,
  output sols_pkg::cmd_t cmd,
  output logic           in_stall
);

  import sols_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_action == ACT_LOAD) ? ST_LOAD : ST_SCAN;
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.hit) begin
          state_nxt = sts.do_reorder ? ST_READ_P : ST_RESP;
        end else if (sts.miss) begin
          state_nxt = ST_RESP;
        end
      end
      ST_READ_P: begin
        state_nxt = ST_WAIT_P;
      end
      ST_WAIT_P: begin
        state_nxt = ST_WRITE_H;
      end
      ST_WRITE_H: begin
        state_nxt = sts.swap_ok ? ST_WRITE_P : ST_RESP;
      end
      ST_WRITE_P: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_READ_P: begin
        cmd.read_p = 1'b1;
      end
      ST_WAIT_P: begin
        cmd.latch_p = 1'b1;
      end
      ST_WRITE_H: begin
        cmd.write_h = sts.swap_ok;
      end
      ST_WRITE_P: begin
        cmd.write_p = 1'b1;
      end
      ST_RESP: begin
        cmd.respond = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/core/sols_dp.sv */
module sols_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sols_pkg::cmd_t                       cmd,
  output sols_pkg::sts_t                       sts,
  input  logic [sols_pkg::LOAD_IDX_W-1:0]      in_load_index,
  input  logic signed [sols_pkg::VAL_W-1:0]    in_key_value,
  input  logic                                 cfg_we,
  input  logic [sols_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sols_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic [sols_pkg::POS_W-1:0]           out_position
);

  import sols_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CNTR_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [VAL_W-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]  load_addr_r, load_addr_nxt;
  logic              load_ok_r, load_ok_nxt;
  logic [CNTR_W-1:0] issue_r, issue_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  entry_t            hit_r, hit_nxt;
  entry_t            part_r, part_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  logic [IDX_W-1:0]  part_idx;
  logic [CNT_W-1:0]  hit_cnt_inc;
  logic [LEN_W-1:0]  cfg_len;

  sols_ram #(
    .W(ENTRY_W),
    .D(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry    = entry_t'(ram_rdata);
  assign part_idx    = (mode_r == MODE_FIRST) ? '0 : hit_idx_r - IDX_W'(1);
  assign hit_cnt_inc = (hit_r.cnt == '1) ? hit_r.cnt : hit_r.cnt + CNT_W'(1);
  assign cfg_len     = cfg_wdata[LEN_W-1:0];

  assign sts.clear_done = (clr_r == IDX_W'(TABLE_DEPTH - 1));
  assign sts.hit        = pend_r && (rd_entry.val == key_r);
  assign sts.miss       = !pend_r && (issue_r >= len_r);
  assign sts.do_reorder = (mode_r == MODE_FIRST || mode_r == MODE_TRANSPOSE ||
                           mode_r == MODE_COUNT) && (cmp_idx_r != '0);
  // count-guarded swap: cnt_h + 1 > cnt_p, taken without overflow
  assign sts.swap_ok    = (mode_r != MODE_COUNT) || (hit_r.cnt >= part_r.cnt);
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    clr_nxt       = clr_r;
    key_nxt       = key_r;
    load_addr_nxt = load_addr_r;
    load_ok_nxt   = load_ok_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_nxt       = hit_r;
    part_nxt      = part_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_raddr     = issue_r[IDX_W-1:0];

    if (cfg_we) begin
      case (cfg_index)
        REG_REORDER_MODE: mode_nxt = cfg_wdata[MODE_W-1:0];
        REG_LIST_LENGTH: begin
          len_nxt = (32'(cfg_len) > 32'(TABLE_DEPTH)) ? CNTR_W'(TABLE_DEPTH)
                                                       : CNTR_W'(cfg_len);
        end
        default: mode_nxt = mode_r;
      endcase
    end

    if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
      clr_nxt   = clr_r + IDX_W'(1);
    end

    if (cmd.start) begin
      key_nxt       = in_key_value;
      load_addr_nxt = IDX_W'(in_load_index);
      load_ok_nxt   = 32'(in_load_index) < 32'(TABLE_DEPTH);
      issue_nxt     = '0;
      pend_nxt      = 1'b0;
      found_nxt     = 1'b0;
    end

    if (cmd.load_wr) begin
      ram_we         = load_ok_r;
      ram_waddr      = load_addr_r;
      ram_wdata.cnt  = '0;
      ram_wdata.val  = key_r;
    end

    if (cmd.scan) begin
      ram_raddr = issue_r[IDX_W-1:0];
      if (issue_r < len_r) begin
        issue_nxt   = issue_r + CNTR_W'(1);
        pend_nxt    = 1'b1;
        cmp_idx_nxt = issue_r[IDX_W-1:0];
      end else begin
        pend_nxt = 1'b0;
      end
      if (sts.hit) begin
        found_nxt   = 1'b1;
        hit_idx_nxt = cmp_idx_r;
        hit_nxt     = rd_entry;
      end
    end

    if (cmd.read_p) begin
      ram_raddr = part_idx;
    end

    if (cmd.latch_p) begin
      part_nxt = rd_entry;
    end

    if (cmd.write_h) begin
      ram_we        = 1'b1;
      ram_waddr     = hit_idx_r;
      ram_wdata.val = part_r.val;
      ram_wdata.cnt = (mode_r == MODE_COUNT) ? part_r.cnt : hit_r.cnt;
    end

    if (cmd.write_p) begin
      ram_we        = 1'b1;
      ram_waddr     = part_idx;
      ram_wdata.val = hit_r.val;
      ram_wdata.cnt = (mode_r == MODE_COUNT) ? hit_cnt_inc : part_r.cnt;
    end

    if (cmd.respond) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_r;
      out_pos_nxt   = found_r ? POS_W'(hit_idx_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TRANSPOSE;
      len_r       <= '0;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    load_addr_r <= load_addr_nxt;
    load_ok_r   <= load_ok_nxt;
    issue_r     <= issue_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_r       <= hit_nxt;
    part_r      <= part_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

/* rtl/core/self_organizing_list_search_unit.sv */
// Load: accepted, then one table write; no result. The next item is taken back in idle.
// Search: entries are read from position 0 on; a hit at position p reports p, after a
// swap with its partner when the mode reorders (none when the count guard blocks it);
// a miss is reported after min(list_length, 1024) entries. One entry per cycle is read
// through the single table read port, so scan length sets the rate.
// Reset (rst_n, synchronous): clears control and config (mode 1, length 0), then a
// clearing pass zeroes all 1024 table entries while in_stall stays high.
module self_organizing_list_search_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [sols_pkg::LOAD_IDX_W-1:0]      in_load_index,
  input  logic signed [sols_pkg::VAL_W-1:0]    in_key_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic [sols_pkg::POS_W-1:0]           out_position,
  input  logic                                 cfg_we,
  input  logic [sols_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sols_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import sols_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sols_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  sols_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_load_index (in_load_index),
    .in_key_value  (in_key_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_position  (out_position)
  );

endmodule

/* rtl/core/sols_chk.sv */
module sols_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_action,
  input logic [sols_pkg::LOAD_IDX_W-1:0]      in_load_index,
  input logic signed [sols_pkg::VAL_W-1:0]    in_key_value,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_found,
  input logic [sols_pkg::POS_W-1:0]           out_position,
  input logic                                 cfg_we,
  input logic [sols_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [sols_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // reset starts the clearing pass with nothing pending on the output
  assert property (@(posedge clk) !rst_n |=> in_stall && !out_valid)
    else $error("input open or result pending right after reset");

  // one transaction in flight: the cycle after an accept is always stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted back to back");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss reported with nonzero position");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_position))
    else $error("stalled result changed or dropped");

endmodule

bind self_organizing_list_search_unit sols_chk u_sols_chk (.*);
